// ===== rtl/oal_pkg.sv =====
`default_nettype none

package oal_pkg;

  // Default configuration of the list
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Fixed field widths of the stream payloads
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned TDATA_W  = 40;

  // Request kinds as they arrive on the input stream
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_POP    = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_BAD_INDEX = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } status_e;

  // Operation the datapath carries out this cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_APPEND,
    OP_DELETE,
    OP_POP,
    OP_READ,
    OP_WRITE
  } op_e;

  // Output register occupancy
  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    op_e     op;
    status_e status;
    logic    load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_le_cnt;
    logic pos_lt_cnt;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/oal_ctrl.sv =====
`default_nettype none

module oal_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  input  wire logic [oal_pkg::CMD_W-1:0] cmd_i,
  input  wire oal_pkg::dp_stat_t       stat_i,
  output      oal_pkg::ctrl_cmd_t      ctrl_o
);

  import oal_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
    out_valid_o = (state_q == ST_HOLD);
    accept      = in_valid_i && in_ready_o;

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !accept) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // Decode the request against the list state
    ctrl_o.op     = OP_NONE;
    ctrl_o.status = STS_OK;
    ctrl_o.load   = accept;
    unique case (cmd_e'(cmd_i))
      CMD_INSERT: begin
        if (!stat_i.pos_le_cnt)  ctrl_o.status = STS_BAD_INDEX;
        else if (stat_i.full)    ctrl_o.status = STS_FULL;
        else                     ctrl_o.op     = OP_INSERT;
      end
      CMD_APPEND: begin
        if (stat_i.full) ctrl_o.status = STS_FULL;
        else             ctrl_o.op     = OP_APPEND;
      end
      CMD_DELETE: begin
        if (stat_i.empty)            ctrl_o.status = STS_EMPTY;
        else if (!stat_i.pos_lt_cnt) ctrl_o.status = STS_BAD_INDEX;
        else                         ctrl_o.op     = OP_DELETE;
      end
      CMD_POP: begin
        if (stat_i.empty) ctrl_o.status = STS_EMPTY;
        else              ctrl_o.op     = OP_POP;
      end
      CMD_READ: begin
        if (!stat_i.pos_lt_cnt) ctrl_o.status = STS_BAD_INDEX;
        else                    ctrl_o.op     = OP_READ;
      end
      CMD_WRITE: begin
        if (!stat_i.pos_lt_cnt) ctrl_o.status = STS_BAD_INDEX;
        else                    ctrl_o.op     = OP_WRITE;
      end
      default: ctrl_o.status = STS_BAD_INDEX;
    endcase
    // No transaction this cycle: leave the list untouched
    if (!accept) ctrl_o.op = OP_NONE;
  end

endmodule

`default_nettype wire

// ===== rtl/oal_dp.sv =====
`default_nettype none

module oal_dp #(
  parameter int unsigned CAPACITY   = oal_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = oal_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire oal_pkg::ctrl_cmd_t                  ctrl_i,
  input  wire logic [oal_pkg::POS_W-1:0]           position_i,
  input  wire logic signed [oal_pkg::IN_W-1:0]     data_in_i,
  output      oal_pkg::dp_stat_t                   stat_o,
  output      logic [oal_pkg::STATUS_W-1:0]        status_o,
  output      logic signed [oal_pkg::IN_W-1:0]     read_value_o,
  output      logic [oal_pkg::OCC_W-1:0]           occupancy_o
);

  import oal_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CW > POS_W) ? CW : POS_W;

  logic signed [DATA_WIDTH-1:0] entries_q [CAPACITY];
  logic signed [DATA_WIDTH-1:0] entries_d [CAPACITY];
  logic [CW-1:0]                count_q, count_d;
  logic [CmpW-1:0]              pos_ext, cnt_ext;
  logic signed [DATA_WIDTH-1:0] word;
  logic [AW-1:0]                rd_idx;

  logic [STATUS_W-1:0]          status_q;
  logic signed [IN_W-1:0]       rdata_q, rdata_d;
  logic [OCC_W-1:0]             occ_q;

  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign word    = DATA_WIDTH'(data_in_i);
  assign rd_idx  = pos_ext[AW-1:0];

  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.pos_le_cnt = (pos_ext <= cnt_ext);
  assign stat_o.pos_lt_cnt = (pos_ext <  cnt_ext);

  // Each cell picks its neighbor, the new word or itself
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      case (ctrl_i.op)
        OP_INSERT: begin
          if (CmpW'(i) == pos_ext)                 entries_d[i] = word;
          else if (i > 0 && CmpW'(i) > pos_ext)    entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
        OP_APPEND: begin
          if (CmpW'(i) == cnt_ext) entries_d[i] = word;
        end
        OP_DELETE: begin
          if (i + 1 < CAPACITY && CmpW'(i) >= pos_ext)
            entries_d[i] = entries_q[(i + 1 < CAPACITY) ? i + 1 : i];
        end
        OP_WRITE: begin
          if (CmpW'(i) == pos_ext) entries_d[i] = word;
        end
        default: ;
      endcase
    end

    case (ctrl_i.op)
      OP_INSERT, OP_APPEND: count_d = count_q + CW'(1);
      OP_DELETE, OP_POP:    count_d = count_q - CW'(1);
      default:              count_d = count_q;
    endcase

    rdata_d = '0;
    if (ctrl_i.op == OP_READ) rdata_d = IN_W'(entries_q[rd_idx]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register: loaded once per accepted transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      status_q <= ctrl_i.status;
      rdata_q  <= rdata_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rdata_q;
  assign occupancy_o  = occ_q;

endmodule

`default_nettype wire

// ===== rtl/ordered_array_list_top.sv =====
`default_nettype none

// Ordered array list: a list of up to CAPACITY signed words of DATA_WIDTH
// bits, kept packed from index 0, with an occupancy count. Each input
// transaction carries one request (insert at index, append, delete at
// index, delete tail, read, write) and produces exactly one output
// transaction with a status (ok, bad index, full, empty), the read value
// (zero unless a read succeeds) and the count after the request. Each
// request is applied in place: the entries form a row of cells
// that all shift up or down at the same edge, and the occupancy count is
// updated at that edge too, so a new request is taken every cycle while
// the output side keeps up. The result sits in an output register, so
// the next request is accepted in the cycle that the pending result is
// taken. Entry contents are not cleared by reset; only the count is, so
// the list starts empty right after reset with no clearing pass.

module ordered_array_list_top #(
  parameter int unsigned CAPACITY   = oal_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = oal_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Request stream
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  // [2:0] cmd, [6:3] position, [38:7] data_in, [39] zero
  input  wire logic [oal_pkg::TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] status, [33:2] read_value, [38:34] occupancy, [39] zero
  output      logic [oal_pkg::TDATA_W-1:0]  m_axis_tdata
);

  import oal_pkg::*;

  ctrl_cmd_t              ctrl;
  dp_stat_t               stat;
  logic [CMD_W-1:0]       cmd;
  logic [POS_W-1:0]       position;
  logic signed [IN_W-1:0] data_in;
  logic [STATUS_W-1:0]    status;
  logic signed [IN_W-1:0] read_value;
  logic [OCC_W-1:0]       occupancy;

  // Unpack the request fields
  assign cmd      = s_axis_tdata[CMD_W-1:0];
  assign position = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
  assign data_in  = s_axis_tdata[CMD_W+POS_W+IN_W-1:CMD_W+POS_W];

  // Decode requests and track the output register
  oal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Hold the entries, the count and the result register
  oal_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .position_i   (position),
    .data_in_i    (data_in),
    .stat_o       (stat),
    .status_o     (status),
    .read_value_o (read_value),
    .occupancy_o  (occupancy)
  );

  // Pack the result fields, lowest first, pad to whole bytes
  assign m_axis_tdata = {1'b0, occupancy, read_value, status};

endmodule

`default_nettype wire
